FILE: src/oscp_pkg.sv
// ----------------------------------------------------------------------------
// oscp_pkg: shared types and constants of the outline segment path unit
// Holds the field widths, the segment and command codes, the queue entry
// layout, the micro-op sequence of the back end and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package oscp_pkg;

  // Width of one incoming point coordinate in font units.
  localparam int POINT_BITS = 16;
  // Fraction bits of the Q16.16 results.
  localparam int FRAC_BITS = 16;
  // Scale register: unsigned with 24 fraction bits.
  localparam int EM_BITS = 25;
  localparam int EM_FRAC = 24;
  localparam int MAP_SHIFT = EM_FRAC - FRAC_BITS;
  localparam logic [EM_BITS-1:0] EM_RESET = EM_BITS'(16384);

  // Two thirds as a Q0.16 constant, rounded to nearest.
  localparam int ELEV_SHIFT = 16;
  localparam int TWO_THIRDS_Q16 = 43691;

  // Shared multiplier and accumulator widths.
  localparam int COORD_W = 32;
  localparam int MUL_A_W = COORD_W + 1;
  localparam int MUL_B_W = EM_BITS + 1;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W = PROD_W + 1;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  // Micro-op step counter and result slots.
  localparam int STEP_W = 3;
  localparam int RES_SLOTS = 6;
  localparam int SLOT_W = 3;

  typedef logic signed [POINT_BITS-1:0] point_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Incoming segment codes.
  typedef enum logic [2:0] {
    ACT_MOVE  = 3'd0,
    ACT_LINE  = 3'd1,
    ACT_CONIC = 3'd2,
    ACT_CUBIC = 3'd3,
    ACT_END   = 3'd4
  } action_t;

  // Outgoing path commands.
  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CUBIC = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  // Work kinds handed from front to back.
  typedef enum logic [2:0] {
    K_MOVE,
    K_LINE,
    K_CONIC,
    K_CUBIC,
    K_CLOSE
  } kind_t;

  // Which input point a mapping step reads.
  typedef enum logic [1:0] {
    PT_END,
    PT_A,
    PT_B
  } pt_sel_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ACC,
    B_CLOSE,
    B_EMIT
  } back_state_t;

  // One queued work item.
  typedef struct packed {
    kind_t  kind;
    logic   close_first;
    point_t a_x;
    point_t a_y;
    point_t b_x;
    point_t b_y;
    point_t end_x;
    point_t end_y;
    coord_t origin_x;
    coord_t origin_y;
  } qent_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // One step of the back end: a mapping or an elevation into a result slot.
  typedef struct packed {
    logic              elev;
    logic              axis_y;
    pt_sel_t           pt_sel;
    logic              base_cur;
    logic [SLOT_W-1:0] dst;
    logic              done;
  } uop_t;

  // Step sequence for each kind. Slots 0..5 are pt1 x/y, pt2 x/y, pt3 x/y.
  // A conic first parks its mapped control point in slots 2 and 3, then the
  // four elevations overwrite slots 0 to 3 in an order that reads each
  // parked value before it is replaced.
  function automatic uop_t uop_lookup(kind_t kind, logic [STEP_W-1:0] step);
    uop_t u;
    u = '0;
    u.pt_sel = PT_END;
    u.axis_y = step[0];
    case (kind)
      K_MOVE, K_LINE: begin
        u.dst  = SLOT_W'(step);
        u.done = (step == STEP_W'(1));
      end
      K_CUBIC: begin
        if (step < STEP_W'(2)) begin
          u.pt_sel = PT_A;
        end else if (step < STEP_W'(4)) begin
          u.pt_sel = PT_B;
        end else begin
          u.pt_sel = PT_END;
        end
        u.dst  = SLOT_W'(step);
        u.done = (step == STEP_W'(5));
      end
      K_CONIC: begin
        if (step < STEP_W'(2)) begin
          u.pt_sel = PT_END;
          u.dst    = SLOT_W'(4) + SLOT_W'(step[0]);
        end else if (step < STEP_W'(4)) begin
          u.pt_sel = PT_A;
          u.dst    = SLOT_W'(2) + SLOT_W'(step[0]);
        end else begin
          u.elev     = 1'b1;
          u.base_cur = (step < STEP_W'(6));
          u.dst      = SLOT_W'(step - STEP_W'(4));
        end
        u.done = (step == STEP_W'(7));
      end
      default: begin
        u.done = 1'b1;
      end
    endcase
    return u;
  endfunction

  // Saturate a wide signed sum to a signed 32-bit coordinate.
  function automatic coord_t sat32(logic [ACC_W-1:0] v);
    coord_t r;
    if ((v[ACC_W-1:COORD_W-1] == '0) || (v[ACC_W-1:COORD_W-1] == '1)) begin
      r = v[COORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/outline_segment_to_cubic_path_unit.sv
// ----------------------------------------------------------------------------
// outline_segment_to_cubic_path_unit: glyph outline segments to cubic paths
// Maps font-unit outline segments into Q16.16 path commands, raising
// conics to cubics and closing open contours on a move or end of glyph.
// ----------------------------------------------------------------------------
// An item is one outline segment. Its results come out in order on the
// out_ channel, the last one of each item flagged by out_last. All
// coordinate work runs through a single shared multiplier, with one
// multiply step and one accumulate step per coordinate or elevation.
// A two-entry queue lets new items be accepted while the back end works
// and while a result waits on out_stall. Unused codes and an end of glyph
// with no open contour produce nothing. The scale register is written
// through the cfg_ port, which is always ready, and should only change
// while idle.
`default_nettype none

module outline_segment_to_cubic_path_unit
  import oscp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_action,
  input  wire point_t              in_ctrl_a_x,
  input  wire point_t              in_ctrl_a_y,
  input  wire point_t              in_ctrl_b_x,
  input  wire point_t              in_ctrl_b_y,
  input  wire point_t              in_end_x,
  input  wire point_t              in_end_y,
  input  wire coord_t              in_origin_x,
  input  wire coord_t              in_origin_y,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_command,
  output coord_t                   out_pt1_x,
  output coord_t                   out_pt1_y,
  output coord_t                   out_pt2_x,
  output coord_t                   out_pt2_y,
  output coord_t                   out_pt3_x,
  output coord_t                   out_pt3_y,
  output logic                     out_last,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [EM_BITS-1:0]  cfg_data
);

  q_status_t q_status;
  logic      push;
  qent_t     push_data;
  logic      pop;
  qent_t     pop_data;

  // Intake and classification.
  oscp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_ctrl_a_x (in_ctrl_a_x),
    .in_ctrl_a_y (in_ctrl_a_y),
    .in_ctrl_b_x (in_ctrl_b_x),
    .in_ctrl_b_y (in_ctrl_b_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  // Work queue.
  oscp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  // Arithmetic sequencer and output register.
  oscp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_status    (q_status),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_command (out_command),
    .out_pt1_x   (out_pt1_x),
    .out_pt1_y   (out_pt1_y),
    .out_pt2_x   (out_pt2_x),
    .out_pt2_y   (out_pt2_y),
    .out_pt3_x   (out_pt3_x),
    .out_pt3_y   (out_pt3_y),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

FILE: src/oscp_front.sv
// ----------------------------------------------------------------------------
// oscp_front: segment intake and classification
// Accepts input items, tracks whether a contour is open, drops segments
// that produce nothing and queues the rest with the kind of work they need.
// ----------------------------------------------------------------------------
`default_nettype none

module oscp_front
  import oscp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire point_t      in_ctrl_a_x,
  input  wire point_t      in_ctrl_a_y,
  input  wire point_t      in_ctrl_b_x,
  input  wire point_t      in_ctrl_b_y,
  input  wire point_t      in_end_x,
  input  wire point_t      in_end_y,
  input  wire coord_t      in_origin_x,
  input  wire coord_t      in_origin_y,
  input  wire q_status_t   q_status,
  output logic             push,
  output qent_t            push_data
);

  logic open_r;
  logic open_nxt;
  logic accept;
  logic want;

  // The queue being full is the only reason to hold off the source.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign push     = accept && want;

  // Classify the segment and work out the contour flag it leaves behind.
  always_comb begin
    want                  = 1'b0;
    open_nxt              = open_r;
    push_data.kind        = K_LINE;
    push_data.close_first = 1'b0;
    push_data.a_x         = in_ctrl_a_x;
    push_data.a_y         = in_ctrl_a_y;
    push_data.b_x         = in_ctrl_b_x;
    push_data.b_y         = in_ctrl_b_y;
    push_data.end_x       = in_end_x;
    push_data.end_y       = in_end_y;
    push_data.origin_x    = in_origin_x;
    push_data.origin_y    = in_origin_y;
    case (action_t'(in_action))
      ACT_MOVE: begin
        want                  = 1'b1;
        push_data.kind        = K_MOVE;
        push_data.close_first = open_r;
        open_nxt              = 1'b1;
      end
      ACT_LINE: begin
        want           = 1'b1;
        push_data.kind = K_LINE;
      end
      ACT_CONIC: begin
        want           = 1'b1;
        push_data.kind = K_CONIC;
      end
      ACT_CUBIC: begin
        want           = 1'b1;
        push_data.kind = K_CUBIC;
      end
      ACT_END: begin
        // End of glyph only produces a close when a contour is open.
        want           = open_r;
        push_data.kind = K_CLOSE;
        open_nxt       = 1'b0;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  // Contour flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (accept) begin
      open_r <= open_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/oscp_queue.sv
// ----------------------------------------------------------------------------
// oscp_queue: short work queue between front and back
// A small first-in first-out buffer of classified segments so that the
// intake and the arithmetic sequencer can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module oscp_queue
  import oscp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire qent_t  push_data,
  input  wire logic   pop,
  output qent_t       pop_data,
  output q_status_t   q_status
);

  qent_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_CW-1:0]  count_r;
  logic [QUEUE_CW-1:0]  count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_data       = entry_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QUEUE_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QUEUE_CW'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/oscp_back.sv
// ----------------------------------------------------------------------------
// oscp_back: coordinate mapping, conic elevation and result output
// Takes queued work one item at a time, runs its mapping and elevation
// steps through one shared multiplier and an accumulate stage, and hands
// the path commands to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oscp_back
  import oscp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [EM_BITS-1:0]  cfg_data,
  input  wire q_status_t           q_status,
  input  wire qent_t               q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_command,
  output coord_t                   out_pt1_x,
  output coord_t                   out_pt1_y,
  output coord_t                   out_pt2_x,
  output coord_t                   out_pt2_y,
  output coord_t                   out_pt3_x,
  output coord_t                   out_pt3_y,
  output logic                     out_last
);

  back_state_t                state_r;
  back_state_t                state_nxt;
  logic [STEP_W-1:0]          step_r;
  logic [STEP_W-1:0]          step_nxt;
  qent_t                      ent_r;
  logic [EM_BITS-1:0]         em_r;
  coord_t                     res_r [RES_SLOTS];
  coord_t                     cur_x_r;
  coord_t                     cur_y_r;
  logic signed [PROD_W-1:0]   prod_r;

  logic                       out_valid_r;
  cmd_t                       out_command_r;
  coord_t                     out_pt1_x_r;
  coord_t                     out_pt1_y_r;
  coord_t                     out_pt2_x_r;
  coord_t                     out_pt2_y_r;
  coord_t                     out_pt3_x_r;
  coord_t                     out_pt3_y_r;
  logic                       out_last_r;

  uop_t                       uop;
  logic                       out_free;
  logic                       acc_we;
  logic                       close_load;
  logic                       emit_load;
  point_t                     pt;
  coord_t                     base;
  coord_t                     ctrl;
  coord_t                     acc_base;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   product;
  logic signed [PROD_W-1:0]   shifted;
  logic [ACC_W-1:0]           sum;
  coord_t                     acc_val;
  cmd_t                       emit_cmd;
  logic                       short_pts;

  // The register port is always open.
  assign cfg_ready = 1'b1;

  assign uop      = uop_lookup(ent_r.kind, step_r);
  assign out_free = !out_valid_r || !out_stall;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      B_IDLE: begin
        step_nxt = '0;
        if (!q_status.empty) begin
          state_nxt = (q_data.kind == K_CLOSE) ? B_CLOSE : B_MUL;
        end
      end
      B_MUL: begin
        state_nxt = B_ACC;
      end
      B_ACC: begin
        if (uop.done) begin
          state_nxt = ent_r.close_first ? B_CLOSE : B_EMIT;
        end else begin
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = B_MUL;
        end
      end
      B_CLOSE: begin
        if (out_free) begin
          state_nxt = (ent_r.kind == K_CLOSE) ? B_IDLE : B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop      = 1'b0;
    acc_we     = 1'b0;
    close_load = 1'b0;
    emit_load  = 1'b0;
    case (state_r)
      B_IDLE:  q_pop      = !q_status.empty;
      B_ACC:   acc_we     = 1'b1;
      B_CLOSE: close_load = out_free;
      B_EMIT:  emit_load  = out_free;
      default: q_pop      = 1'b0;
    endcase
  end

  // Multiplier operands: a font-unit point times em_scale, or a control
  // offset from its base point times two thirds.
  always_comb begin
    case (uop.pt_sel)
      PT_A:    pt = uop.axis_y ? ent_r.a_y : ent_r.a_x;
      PT_B:    pt = uop.axis_y ? ent_r.b_y : ent_r.b_x;
      default: pt = uop.axis_y ? ent_r.end_y : ent_r.end_x;
    endcase
    if (uop.base_cur) begin
      base = uop.axis_y ? cur_y_r : cur_x_r;
    end else begin
      base = uop.axis_y ? res_r[5] : res_r[4];
    end
    ctrl = uop.axis_y ? res_r[3] : res_r[2];
    if (uop.elev) begin
      mul_a = $signed({ctrl[COORD_W-1], ctrl}) - $signed({base[COORD_W-1], base});
      mul_b = MUL_B_W'(TWO_THIRDS_Q16);
    end else begin
      mul_a = $signed({{(MUL_A_W-POINT_BITS){pt[POINT_BITS-1]}}, pt});
      mul_b = $signed({1'b0, em_r});
    end
    product = mul_a * mul_b;
  end

  // Accumulate: floor shift of the product, added to the origin or the
  // base point (subtracted for a flipped y), then saturated.
  always_comb begin
    shifted  = uop.elev ? (prod_r >>> ELEV_SHIFT) : (prod_r >>> MAP_SHIFT);
    acc_base = uop.elev ? base : (uop.axis_y ? ent_r.origin_y : ent_r.origin_x);
    if (!uop.elev && uop.axis_y) begin
      sum = {{(ACC_W-COORD_W){acc_base[COORD_W-1]}}, acc_base}
          - {shifted[PROD_W-1], shifted};
    end else begin
      sum = {{(ACC_W-COORD_W){acc_base[COORD_W-1]}}, acc_base}
          + {shifted[PROD_W-1], shifted};
    end
    acc_val = sat32(sum);
  end

  // Command of the main result and whether it carries only pt1.
  always_comb begin
    case (ent_r.kind)
      K_MOVE: begin
        emit_cmd  = CMD_MOVE;
        short_pts = 1'b1;
      end
      K_LINE: begin
        emit_cmd  = CMD_LINE;
        short_pts = 1'b1;
      end
      default: begin
        emit_cmd  = CMD_CUBIC;
        short_pts = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      em_r        <= EM_RESET;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= close_load || emit_load || (out_valid_r && out_stall);
      if (cfg_valid && cfg_ready) begin
        em_r <= cfg_data;
      end
      // The current point moves to the segment end once it is emitted.
      if (emit_load) begin
        cur_x_r <= short_pts ? res_r[0] : res_r[4];
        cur_y_r <= short_pts ? res_r[1] : res_r[5];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (state_r == B_MUL) begin
      prod_r <= product;
    end
    if (acc_we) begin
      res_r[uop.dst] <= acc_val;
    end
    if (close_load) begin
      out_command_r <= CMD_CLOSE;
      out_pt1_x_r   <= '0;
      out_pt1_y_r   <= '0;
      out_pt2_x_r   <= '0;
      out_pt2_y_r   <= '0;
      out_pt3_x_r   <= '0;
      out_pt3_y_r   <= '0;
      out_last_r    <= (ent_r.kind == K_CLOSE);
    end else if (emit_load) begin
      out_command_r <= emit_cmd;
      out_pt1_x_r   <= res_r[0];
      out_pt1_y_r   <= res_r[1];
      out_pt2_x_r   <= short_pts ? '0 : res_r[2];
      out_pt2_y_r   <= short_pts ? '0 : res_r[3];
      out_pt3_x_r   <= short_pts ? '0 : res_r[4];
      out_pt3_y_r   <= short_pts ? '0 : res_r[5];
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;
  assign out_pt1_x   = out_pt1_x_r;
  assign out_pt1_y   = out_pt1_y_r;
  assign out_pt2_x   = out_pt2_x_r;
  assign out_pt2_y   = out_pt2_y_r;
  assign out_pt3_x   = out_pt3_x_r;
  assign out_pt3_y   = out_pt3_y_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

FILE: src/oscp_checker.sv
// ----------------------------------------------------------------------------
// oscp_checker: port-level checks of the outline segment path unit
// Watches the result channel for reset behavior, held results and the
// point layout of each command, and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module oscp_checker
  import oscp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_command,
  input wire coord_t      out_pt1_x,
  input wire coord_t      out_pt1_y,
  input wire coord_t      out_pt2_x,
  input wire coord_t      out_pt2_y,
  input wire coord_t      out_pt3_x,
  input wire coord_t      out_pt3_y,
  input wire logic        out_last
);

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its command, pt1, pt3 and last flag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command)
      && $stable(out_pt1_x) && $stable(out_pt1_y) && $stable(out_pt3_x)
      && $stable(out_pt3_y) && $stable(out_last))
    else $error("stalled result changed");

  // A close carries no points.
  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_CLOSE |-> out_pt1_x == '0 && out_pt1_y == '0
      && out_pt2_x == '0 && out_pt2_y == '0 && out_pt3_x == '0 && out_pt3_y == '0)
    else $error("close result with nonzero points");

  // A move or a line carries only its target point.
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command == CMD_MOVE || out_command == CMD_LINE)
      |-> out_pt2_x == '0 && out_pt2_y == '0 && out_pt3_x == '0 && out_pt3_y == '0)
    else $error("move or line with extra points");

  // Only a close ahead of a move can be a non-final result of its item.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command != CMD_CLOSE |-> out_last)
    else $error("non-close result not marked last");

endmodule

bind outline_segment_to_cubic_path_unit oscp_checker u_oscp_checker (.*);

`default_nettype wire
